// File: hdl/hrut_pkg.sv
// Shared types and constants of the HID report usage table.
package hrut_pkg;

  // Operation codes.
  localparam logic [1:0] OP_REGISTER   = 2'd0;
  localparam logic [1:0] OP_WRITE      = 2'd1;
  localparam logic [1:0] OP_QUERY      = 2'd2;
  localparam logic [1:0] OP_UNREGISTER = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADPARAM = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_NOSLOT   = 2'd3;

  // Device kinds; all but KIND_NONE carry a default usage mapping.
  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_MOUSE    = 3'd1;
  localparam logic [2:0] KIND_KEYBOARD = 3'd2;
  localparam logic [2:0] KIND_GAMEPAD  = 3'd3;

  // Usage pages and usages of the default mappings.
  localparam logic [15:0] PAGE_DESKTOP = 16'h0001;
  localparam logic [15:0] PAGE_KEYS    = 16'h0007;
  localparam logic [15:0] USE_X        = 16'h0030;
  localparam logic [15:0] USE_Y        = 16'h0031;
  localparam logic [15:0] USE_WHEEL    = 16'h0038;
  localparam logic [15:0] USE_KEY0     = 16'h0004;
  localparam logic [15:0] KEY_COUNT    = 16'd6;

  // Stored report head and the slot memory word {kind, head}.
  localparam int HEAD_BYTES = 8;
  localparam int HEAD_W     = 64;
  localparam int KIND_W     = 3;
  localparam int WORD_W     = KIND_W + HEAD_W;

  // Free-slot search works on groups of this many slots.
  localparam int GRP   = 16;
  localparam int GRP_W = 4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  device_id;
    logic [2:0]  device_type;
    logic [7:0]  byte_index;
    logic [7:0]  byte_value;
    logic [15:0] usage_page;
    logic [15:0] usage_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  assigned_id;
    logic [15:0] field_value;
  } out_item_t;

  // Usage class worked out before the slot's kind is known.
  typedef enum logic [2:0] {
    UC_NONE,
    UC_X,
    UC_Y,
    UC_WHEEL,
    UC_KEY
  } uclass_t;

  // Classified transaction as it waits between front and back.
  typedef struct packed {
    logic [1:0]  opcode;
    logic        bad_id;
    logic [7:0]  slot;
    logic [2:0]  kind;
    logic        byte_ok;
    logic [2:0]  byte_lane;
    logic [7:0]  byte_value;
    uclass_t     uclass;
    logic [2:0]  key_idx;
  } q_entry_t;

  typedef enum logic {
    BK_FETCH,
    BK_EXEC
  } bk_state_t;

endpackage

// File: hdl/hrut_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hrut_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/hrut_front.sv
// Front end: accepts transactions, classifies them and queues them for the back end.
module hrut_front #(
  parameter int MAX_DEVICES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  hrut_pkg::in_item_t in_item,
  input  logic              pop,
  output logic              head_valid,
  output hrut_pkg::q_entry_t head
);

  hrut_pkg::q_entry_t q_r [2];
  hrut_pkg::q_entry_t ent;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic       accept;

  assign busy       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_r[rp_r];
  assign accept     = start && !busy;

  // Everything that does not depend on the slot's stored state is decided here.
  always_comb begin
    ent            = '0;
    ent.opcode     = in_item.opcode;
    ent.bad_id     = (in_item.device_id == 8'd0) ||
                     (in_item.device_id > 8'(MAX_DEVICES));
    ent.slot       = in_item.device_id - 8'd1;
    ent.kind       = in_item.device_type;
    ent.byte_ok    = (in_item.byte_index[7:3] == 5'd0);
    ent.byte_lane  = in_item.byte_index[2:0];
    ent.byte_value = in_item.byte_value;
    ent.uclass     = hrut_pkg::UC_NONE;
    ent.key_idx    = 3'd0;
    if (in_item.usage_page == hrut_pkg::PAGE_DESKTOP) begin
      if (in_item.usage_code == hrut_pkg::USE_X) begin
        ent.uclass = hrut_pkg::UC_X;
      end else if (in_item.usage_code == hrut_pkg::USE_Y) begin
        ent.uclass = hrut_pkg::UC_Y;
      end else if (in_item.usage_code == hrut_pkg::USE_WHEEL) begin
        ent.uclass = hrut_pkg::UC_WHEEL;
      end
    end else if (in_item.usage_page == hrut_pkg::PAGE_KEYS &&
                 in_item.usage_code >= hrut_pkg::USE_KEY0 &&
                 in_item.usage_code < hrut_pkg::USE_KEY0 + hrut_pkg::KEY_COUNT) begin
      ent.uclass  = hrut_pkg::UC_KEY;
      ent.key_idx = 3'(in_item.usage_code - hrut_pkg::USE_KEY0);
    end
  end

  always_comb begin
    wp_nxt  = accept ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = 2'(cnt_r + {1'b0, accept} - {1'b0, pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wp_r] <= ent;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !pop) |=> (cnt_r == 2'd2) && $stable(wp_r))
    else $error("full queue took a transaction");

endmodule

// File: hdl/hrut_back.sv
// Back end: slot state, report memory and execution of queued transactions.
module hrut_back #(
  parameter int MAX_DEVICES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  hrut_pkg::q_entry_t head,
  output logic               pop,
  output logic               out_valid,
  output hrut_pkg::out_item_t out_item
);

  localparam int SLOT_W = $clog2(MAX_DEVICES);
  localparam int NGROUP = (MAX_DEVICES + hrut_pkg::GRP - 1) / hrut_pkg::GRP;
  localparam int PAD    = NGROUP * hrut_pkg::GRP;

  hrut_pkg::bk_state_t state_r, state_nxt;
  hrut_pkg::q_entry_t  cur_r;
  hrut_pkg::out_item_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [MAX_DEVICES-1:0] busy_r, busy_nxt;
  logic [MAX_DEVICES-1:0] wvalid_r, wvalid_nxt;
  logic [PAD-1:0]         busy_pad;

  logic [NGROUP-1:0]        gfree, grp_free_r;
  logic [hrut_pkg::GRP_W-1:0] glow [NGROUP];
  logic [hrut_pkg::GRP_W-1:0] grp_low_r [NGROUP];

  logic                        ram_we;
  logic [SLOT_W-1:0]           ram_waddr;
  logic [hrut_pkg::WORD_W-1:0] ram_wdata;
  logic [hrut_pkg::WORD_W-1:0] ram_rdata;

  logic [SLOT_W-1:0]           slot;
  logic [hrut_pkg::WORD_W-1:0] word;
  logic [hrut_pkg::KIND_W-1:0] def_kind;
  logic [hrut_pkg::HEAD_W-1:0] cur_head, new_head;
  logic [7:0]                  hb [hrut_pkg::HEAD_BYTES];
  logic                        found;
  logic [7:0]                  free_idx;
  logic                        q_hit;
  logic                        q_wide;
  logic [2:0]                  q_byte;

  hrut_ram #(
    .WIDTH(hrut_pkg::WORD_W),
    .DEPTH(MAX_DEVICES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (pop),
    .raddr(head.slot[SLOT_W-1:0]),
    .rdata(ram_rdata)
  );

  // Slots past the table count as taken so the search never lands there.
  for (genvar i = 0; i < PAD; i++) begin : g_pad
    if (i < MAX_DEVICES) begin : g_real
      assign busy_pad[i] = busy_r[i];
    end else begin : g_fill
      assign busy_pad[i] = 1'b1;
    end
  end

  // First level of the free-slot search: lowest free slot in each group.
  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      gfree[g] = 1'b0;
      glow[g]  = '0;
      for (int b = hrut_pkg::GRP - 1; b >= 0; b--) begin
        if (!busy_pad[g * hrut_pkg::GRP + b]) begin
          gfree[g] = 1'b1;
          glow[g]  = hrut_pkg::GRP_W'(b);
        end
      end
    end
  end

  // Second level: lowest group with a free slot.
  always_comb begin
    found    = 1'b0;
    free_idx = 8'd0;
    for (int g = NGROUP - 1; g >= 0; g--) begin
      if (grp_free_r[g]) begin
        found    = 1'b1;
        free_idx = 8'(g * hrut_pkg::GRP) + 8'(grp_low_r[g]);
      end
    end
  end

  // A slot that was never written since reset holds its reset contents.
  always_comb begin
    slot = cur_r.slot[SLOT_W-1:0];
    if (slot == SLOT_W'(0)) begin
      def_kind = hrut_pkg::KIND_KEYBOARD;
    end else if (slot == SLOT_W'(1)) begin
      def_kind = hrut_pkg::KIND_MOUSE;
    end else begin
      def_kind = hrut_pkg::KIND_NONE;
    end
    word     = wvalid_r[slot] ? ram_rdata : {def_kind, {hrut_pkg::HEAD_W{1'b0}}};
    cur_head = word[hrut_pkg::HEAD_W-1:0];
    for (int i = 0; i < hrut_pkg::HEAD_BYTES; i++) begin
      hb[i] = cur_head[8*i +: 8];
    end
    new_head = cur_head;
    new_head[8*cur_r.byte_lane +: 8] = cur_r.byte_value;
  end

  // Default usage mapping of the slot's kind; offsets are whole bytes.
  always_comb begin
    q_hit  = 1'b0;
    q_wide = 1'b0;
    q_byte = 3'd0;
    unique case (word[hrut_pkg::WORD_W-1:hrut_pkg::HEAD_W])
      hrut_pkg::KIND_MOUSE: begin
        unique case (cur_r.uclass)
          hrut_pkg::UC_X: begin
            q_hit  = 1'b1;
            q_byte = 3'd1;
          end
          hrut_pkg::UC_Y: begin
            q_hit  = 1'b1;
            q_byte = 3'd2;
          end
          hrut_pkg::UC_WHEEL: begin
            q_hit  = 1'b1;
            q_byte = 3'd3;
          end
          default: ;
        endcase
      end
      hrut_pkg::KIND_KEYBOARD: begin
        if (cur_r.uclass == hrut_pkg::UC_KEY) begin
          q_hit  = 1'b1;
          q_byte = 3'(cur_r.key_idx + 3'd1);
        end
      end
      hrut_pkg::KIND_GAMEPAD: begin
        unique case (cur_r.uclass)
          hrut_pkg::UC_X: begin
            q_hit  = 1'b1;
            q_wide = 1'b1;
            q_byte = 3'd0;
          end
          hrut_pkg::UC_Y: begin
            q_hit  = 1'b1;
            q_wide = 1'b1;
            q_byte = 3'd2;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    pop           = 1'b0;
    busy_nxt      = busy_r;
    wvalid_nxt    = wvalid_r;
    ram_we        = 1'b0;
    ram_waddr     = slot;
    ram_wdata     = {word[hrut_pkg::WORD_W-1:hrut_pkg::HEAD_W], new_head};
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    unique case (state_r)
      hrut_pkg::BK_FETCH: begin
        if (head_valid) begin
          pop       = 1'b1;
          state_nxt = hrut_pkg::BK_EXEC;
        end
      end
      hrut_pkg::BK_EXEC: begin
        state_nxt          = hrut_pkg::BK_FETCH;
        out_valid_nxt      = 1'b1;
        out_nxt.status     = hrut_pkg::ST_OK;
        if (cur_r.opcode == hrut_pkg::OP_REGISTER) begin
          if (found) begin
            busy_nxt[free_idx[SLOT_W-1:0]]   = 1'b1;
            wvalid_nxt[free_idx[SLOT_W-1:0]] = 1'b1;
            ram_we              = 1'b1;
            ram_waddr           = free_idx[SLOT_W-1:0];
            ram_wdata           = {cur_r.kind, {hrut_pkg::HEAD_W{1'b0}}};
            out_nxt.assigned_id = free_idx + 8'd1;
          end else begin
            out_nxt.status = hrut_pkg::ST_NOSLOT;
          end
        end else if (cur_r.bad_id) begin
          out_nxt.status = hrut_pkg::ST_BADPARAM;
        end else if (!busy_r[slot]) begin
          out_nxt.status = hrut_pkg::ST_NOTFOUND;
        end else begin
          unique case (cur_r.opcode)
            hrut_pkg::OP_WRITE: begin
              // Bytes past the stored head are accepted and dropped.
              if (cur_r.byte_ok) begin
                ram_we           = 1'b1;
                wvalid_nxt[slot] = 1'b1;
              end
            end
            hrut_pkg::OP_QUERY: begin
              if (q_hit) begin
                out_nxt.field_value = {q_wide ? hb[3'(q_byte + 3'd1)] : 8'd0, hb[q_byte]};
              end else begin
                out_nxt.status = hrut_pkg::ST_NOTFOUND;
              end
            end
            hrut_pkg::OP_UNREGISTER: begin
              busy_nxt[slot] = 1'b0;
            end
            default: ;
          endcase
        end
      end
      default: state_nxt = hrut_pkg::BK_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hrut_pkg::BK_FETCH;
      out_valid_r <= 1'b0;
      busy_r      <= MAX_DEVICES'(2'b11);
      wvalid_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      busy_r      <= busy_nxt;
      wvalid_r    <= wvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r      <= head;
      grp_free_r <= gfree;
      for (int g = 0; g < NGROUP; g++) begin
        grp_low_r[g] <= glow[g];
      end
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == hrut_pkg::BK_EXEC))
    else $error("result strobe without an executed transaction");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_id_only_on_register: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.assigned_id != 8'd0) |->
      (out_r.status == hrut_pkg::ST_OK) && (cur_r.opcode == hrut_pkg::OP_REGISTER))
    else $error("device id returned by a transaction other than register");

  a_register_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hrut_pkg::BK_EXEC && cur_r.opcode == hrut_pkg::OP_REGISTER && found) |=>
      $countones(busy_r) == $countones($past(busy_r)) + 1)
    else $error("register did not take exactly one slot");

endmodule

// File: hdl/hid_report_usage_table.sv
// HID report usage table: device slots, stored report heads and usage lookup.
//
// A transaction is taken when start is high and busy is low; in_item carries
// the opcode (register, write report byte, query usage, unregister) and its
// operands. Each transaction gives exactly one result: out_valid is high for
// one cycle while out_item holds status, assigned id and the extracted field.
// The receiver cannot hold results off; results come in transaction order.
// The back end pops a queued transaction in its fetch state, which reads the
// slot memory, then executes it in its exec state, which writes it back and
// registers the result; only then does it take the next transaction.
// A two-entry queue between front and back keeps start accepted while the
// back end works; busy rises only when that queue is full.
// Reset (rst_n low at a clock edge) empties the queue, marks slot 0 busy as a
// keyboard and slot 1 busy as a mouse, frees all other slots and zeroes all
// report heads. The table is ready in the cycle after reset; there is no
// clearing pass.
module hid_report_usage_table #(
  parameter int MAX_DEVICES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  hrut_pkg::in_item_t  in_item,
  output logic                out_valid,
  output hrut_pkg::out_item_t out_item
);

  hrut_pkg::q_entry_t head;
  logic               head_valid;
  logic               pop;

  hrut_front #(
    .MAX_DEVICES(MAX_DEVICES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  hrut_back #(
    .MAX_DEVICES(MAX_DEVICES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
